// ----- src/mck_pkg.sv -----
package mck_pkg;

    // Classification of one input character
    typedef enum logic [1:0] {
        K_NONE,
        K_SPACE,
        K_CODE
    } t_kind;

    // Decoded character: symbol count and dash pattern, first symbol at bit 4
    typedef struct packed {
        t_kind      kind;
        logic [2:0] len;
        logic [4:0] pat;
    } t_desc;

    // One lamp segment as the back end produces it
    typedef struct packed {
        logic        lamp_on;
        logic [13:0] duration_ticks;
        logic        last_of_char;
    } t_seg;

    localparam logic [7:0] C_CHAR_A     = 8'h41;
    localparam logic [7:0] C_CHAR_Z     = 8'h5A;
    localparam logic [7:0] C_CHAR_0     = 8'h30;
    localparam logic [7:0] C_CHAR_9     = 8'h39;
    localparam logic [7:0] C_CHAR_SPACE = 8'h20;

    localparam logic [11:0] C_DOT_TICKS_RST = 12'd100;

    // Unit counts of the segment kinds
    localparam logic [2:0] C_UNITS_DOT   = 3'd1;
    localparam logic [2:0] C_UNITS_DASH  = 3'd3;
    localparam logic [2:0] C_UNITS_GAP   = 3'd1;
    localparam logic [2:0] C_UNITS_CHAR  = 3'd2;
    localparam logic [2:0] C_UNITS_SPACE = 3'd4;

    // Letter table: {len, pattern}, dash = 1, read from bit 4 downward
    localparam logic [7:0] C_ALPHA [26] = '{
        {3'd2, 5'b01000}, {3'd4, 5'b10000}, {3'd4, 5'b10100}, {3'd3, 5'b10000},
        {3'd1, 5'b00000}, {3'd4, 5'b00100}, {3'd3, 5'b11000}, {3'd4, 5'b00000},
        {3'd2, 5'b00000}, {3'd4, 5'b01110}, {3'd3, 5'b10100}, {3'd4, 5'b01000},
        {3'd2, 5'b11000}, {3'd2, 5'b10000}, {3'd3, 5'b11100}, {3'd4, 5'b01100},
        {3'd4, 5'b11010}, {3'd3, 5'b01000}, {3'd3, 5'b00000}, {3'd1, 5'b10000},
        {3'd3, 5'b00100}, {3'd4, 5'b00010}, {3'd3, 5'b01100}, {3'd4, 5'b10010},
        {3'd4, 5'b10110}, {3'd4, 5'b11000}
    };

    // Digit table: always five symbols
    localparam logic [4:0] C_DIGIT [10] = '{
        5'b11111, 5'b01111, 5'b00111, 5'b00011, 5'b00001,
        5'b00000, 5'b10000, 5'b11000, 5'b11100, 5'b11110
    };

    // Look up one character
    function automatic t_desc char_desc(input logic [7:0] code);
        t_desc      d;
        logic [7:0] off;
        logic [7:0] ent;
        d   = '{kind: K_NONE, len: 3'd0, pat: 5'b00000};
        off = 8'd0;
        ent = 8'd0;
        if (code >= C_CHAR_A && code <= C_CHAR_Z) begin
            off    = code - C_CHAR_A;
            ent    = C_ALPHA[off[4:0]];
            d.kind = K_CODE;
            d.len  = ent[7:5];
            d.pat  = ent[4:0];
        end else if (code >= C_CHAR_0 && code <= C_CHAR_9) begin
            off    = code - C_CHAR_0;
            d.kind = K_CODE;
            d.len  = 3'd5;
            d.pat  = C_DIGIT[off[3:0]];
        end else if (code == C_CHAR_SPACE) begin
            d.kind = K_SPACE;
        end
        return d;
    endfunction

endpackage

// ----- src/morse_character_keyer_unit.sv -----
// Path: an accepted word passes the front register, descriptor queue, sequencer
// registers and output register. Throughput: one segment per cycle while i_stall
// is low; n-symbol letters and digits give 2n+1 segments, a space 1, others none.
// The front stage and the descriptor queue take new words while segments drain.
// Reset: synchronous active low; empties the pipeline and sets dot_ticks to 100.
module morse_character_keyer_unit #(
    parameter int QDEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_code,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_lamp_on,
    output logic [13:0] o_duration_ticks,
    output logic        o_last_of_char,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [11:0] i_cfg_data
);
    import mck_pkg::*;

    logic [11:0] r_dot_ticks;
    logic        push;
    logic        q_ready;
    logic        q_valid;
    logic        pop;
    t_desc       f_desc;
    t_desc       q_desc;

    // configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_ticks <= C_DOT_TICKS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_dot_ticks <= i_cfg_data;
        end
    end

    mck_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_char_code (i_char_code),
        .o_push      (push),
        .o_desc      (f_desc),
        .i_q_ready   (q_ready)
    );

    mck_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (f_desc),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_desc  (q_desc),
        .i_pop   (pop)
    );

    mck_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_dot_ticks      (r_dot_ticks),
        .i_q_valid        (q_valid),
        .i_q_desc         (q_desc),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_lamp_on        (o_lamp_on),
        .o_duration_ticks (o_duration_ticks),
        .o_last_of_char   (o_last_of_char)
    );

endmodule

// ----- src/mck_front.sv -----
module mck_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [7:0]    i_char_code,
    output logic          o_push,
    output mck_pkg::t_desc o_desc,
    input  logic          i_q_ready
);
    import mck_pkg::*;

    logic  r_vld;
    t_desc r_desc;
    t_desc n_desc;
    logic  acc;

    // hold the word while the queue is full
    assign o_stall = r_vld && !i_q_ready;
    assign acc     = i_valid && !o_stall;
    assign n_desc  = char_desc(i_char_code);
    assign o_push  = r_vld;
    assign o_desc  = r_desc;

    // classify and register; drop characters that send nothing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (acc) begin
            r_vld <= (n_desc.kind != K_NONE);
        end else if (i_q_ready) begin
            r_vld <= 1'b0;
        end
        if (acc) begin
            r_desc <= n_desc;
        end
    end

endmodule

// ----- src/mck_queue.sv -----
module mck_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mck_pkg::t_desc i_desc,
    output logic           o_ready,
    output logic           o_valid,
    output mck_pkg::t_desc o_desc,
    input  logic           i_pop
);
    import mck_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_desc         r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_desc  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

endmodule

// ----- src/mck_back.sv -----
module mck_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [11:0]    i_dot_ticks,
    input  logic           i_q_valid,
    input  mck_pkg::t_desc i_q_desc,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output logic           o_lamp_on,
    output logic [13:0]    o_duration_ticks,
    output logic           o_last_of_char
);
    import mck_pkg::*;

    logic       r_busy;
    logic       r_space;
    logic       r_phase_on;
    logic [2:0] r_left;
    logic [4:0] r_pat;
    logic       r_ovld;
    t_seg       r_seg;

    t_seg       seg;
    logic [2:0] units;
    logic       out_free;
    logic       produce;

    // pick the next segment from the sequencer state
    always_comb begin
        seg.lamp_on      = 1'b0;
        seg.last_of_char = 1'b0;
        units            = C_UNITS_GAP;
        if (r_space) begin
            units            = C_UNITS_SPACE;
            seg.last_of_char = 1'b1;
        end else if (r_left != 3'd0) begin
            if (r_phase_on) begin
                seg.lamp_on = 1'b1;
                units       = r_pat[4] ? C_UNITS_DASH : C_UNITS_DOT;
            end
        end else begin
            units            = C_UNITS_CHAR;
            seg.last_of_char = 1'b1;
        end
    end

    // scale units by the dot length with shifts and one add
    always_comb begin
        case (units)
            3'd2:    seg.duration_ticks = {1'b0, i_dot_ticks, 1'b0};
            3'd3:    seg.duration_ticks = {1'b0, i_dot_ticks, 1'b0} + {2'b00, i_dot_ticks};
            3'd4:    seg.duration_ticks = {i_dot_ticks, 2'b00};
            default: seg.duration_ticks = {2'b00, i_dot_ticks};
        endcase
    end

    assign out_free = !r_ovld || !i_stall;
    assign produce  = r_busy && out_free;
    assign o_pop    = i_q_valid && (!r_busy || (produce && seg.last_of_char));

    // step the sequencer; load the next character as the last segment leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
        end else if (produce && seg.last_of_char) begin
            r_busy <= 1'b0;
        end
        if (o_pop) begin
            r_space    <= (i_q_desc.kind == K_SPACE);
            r_left     <= i_q_desc.len;
            r_pat      <= i_q_desc.pat;
            r_phase_on <= 1'b1;
        end else if (produce) begin
            if (r_phase_on) begin
                r_phase_on <= 1'b0;
            end else begin
                r_phase_on <= 1'b1;
                r_left     <= r_left - 1'b1;
                r_pat      <= {r_pat[3:0], 1'b0};
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (out_free) begin
            r_ovld <= produce;
        end
        if (out_free) begin
            r_seg <= seg;
        end
    end

    assign o_valid          = r_ovld;
    assign o_lamp_on        = r_seg.lamp_on;
    assign o_duration_ticks = r_seg.duration_ticks;
    assign o_last_of_char   = r_seg.last_of_char;

endmodule

// ----- src/mck_checker.sv -----
module mck_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [7:0]  i_char_code,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_lamp_on,
    input logic [13:0] o_duration_ticks,
    input logic        o_last_of_char,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [11:0] i_cfg_data
);

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_lamp_on)
            && $stable(o_duration_ticks) && $stable(o_last_of_char))
        else $error("stalled output word changed");

    // a character always closes with a lamp-off segment
    a_last_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_of_char |-> !o_lamp_on)
        else $error("closing segment has lamp on");

    // input stall is low right after reset
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_stall)
        else $error("input stalled right after reset");

endmodule

bind morse_character_keyer_unit mck_checker u_mck_checker (.*);
